[hw/rtl/dnv_pkg.sv]
// Types and constants shared by the DNS name validator files.
package dnv_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ST_OVER_WIRE = 3'd2;
  localparam logic [2:0] ST_OVER_CFG  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam logic [7:0] NAME_TYPE_MASK = 8'hc0;
  localparam logic [7:0] MAX_LEN_RESET  = 8'd255;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } dnv_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_length;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] name_len;
    logic [7:0] label_count;
  } dnv_out_t;

  typedef struct packed {
    logic       want_length;
    logic [5:0] label_left;
    logic [8:0] total_len;
    logic [7:0] labels_seen;
  } dnv_state_t;

  localparam dnv_state_t NAME_START = '{
    want_length: 1'b1,
    label_left:  6'd0,
    total_len:   9'd0,
    labels_seen: 8'd1
  };

endpackage

[hw/rtl/dnv_step.sv]
// Per-byte parse step: result fields and next parser state for one item.
module dnv_step #(
  parameter int MAX_NAME_LEN = 255
) (
  input  dnv_pkg::dnv_in_t    item,
  input  dnv_pkg::dnv_state_t cur,
  input  logic [7:0]          max_len,
  output dnv_pkg::dnv_out_t   res,
  output dnv_pkg::dnv_state_t nxt
);
  import dnv_pkg::*;

  logic [8:0] grown;
  logic [2:0] st;
  logic       done;
  logic [5:0] left_dec;
  dnv_state_t upd;

  assign grown    = cur.total_len + {1'b0, item.in_byte} + 9'd1;
  assign left_dec = cur.label_left - 6'd1;

  always_comb begin
    upd           = cur;
    st            = ST_OK;
    done          = 1'b0;
    res.out_byte  = item.in_byte;
    res.is_length = cur.want_length;
    if (cur.want_length) begin
      if ((item.in_byte & NAME_TYPE_MASK) != 8'd0) begin
        st = ST_BAD_TYPE;
      end else if (grown > 9'(MAX_NAME_LEN)) begin
        st = ST_OVER_WIRE;
      end else if (grown > {1'b0, max_len}) begin
        st = ST_OVER_CFG;
      end
      if (st != ST_OK) begin
        done = 1'b1;
      end else if (item.in_byte == 8'd0) begin
        upd.total_len = grown;
        done          = 1'b1;
      end else begin
        upd.total_len   = grown;
        upd.label_left  = item.in_byte[5:0];
        upd.want_length = 1'b0;
        upd.labels_seen = cur.labels_seen + 8'd1;
        if (item.in_last) begin
          st   = ST_TRUNC;
          done = 1'b1;
        end
      end
    end else begin
      // Label content is lowercased in ASCII.
      if (item.in_byte >= 8'h41 && item.in_byte <= 8'h5a) begin
        res.out_byte = item.in_byte + 8'h20;
      end
      upd.label_left = left_dec;
      if (left_dec == 6'd0) begin
        upd.want_length = 1'b1;
      end
      if (item.in_last) begin
        st   = ST_TRUNC;
        done = 1'b1;
      end
    end
    res.done_res    = done;
    res.status      = st;
    res.name_len    = upd.total_len[7:0];
    res.label_count = upd.labels_seen;
    nxt             = done ? NAME_START : upd;
  end

endmodule

[hw/rtl/dns_name_wire_validator_unit.sv]
// Streaming validator of uncompressed wire-format DNS names, one byte per item.
//
// Each input item carries one byte of a wire-format name and a flag that marks
// the last byte available. Every item gives exactly one result item: the byte
// echoed (lowercased when it is label content), whether it was a length byte,
// and, when the name ends on it, the final status, total length and label
// count. One item is taken every clock cycle while the result side does not stall; an item sits in an input register
// and moves to the result register when that one is free, so a result is offered
// once its item has passed through both registers, or later while an earlier
// result waits. The parser state register loops back through the combinational step logic.
// cfg_data sets the largest accepted name length and should be written only while
// no item is in flight.
module dns_name_wire_validator_unit #(
  parameter int MAX_NAME_LEN = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dnv_pkg::dnv_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dnv_pkg::dnv_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import dnv_pkg::*;

  logic       s1_valid_r;
  dnv_in_t    s1_data_r;
  logic       out_valid_r;
  dnv_out_t   out_data_r;
  dnv_state_t state_r;
  logic [7:0] max_len_r;

  logic       advance;
  dnv_out_t   res_nxt;
  dnv_state_t state_nxt;

  dnv_step #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_step (
    .item    (s1_data_r),
    .cur     (state_r),
    .max_len (max_len_r),
    .res     (res_nxt),
    .nxt     (state_nxt)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= NAME_START;
      max_len_r   <= MAX_LEN_RESET;
    end else begin
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A finished name leaves the parser ready for a fresh name.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.done_res |=> state_r == NAME_START)
    else $error("parser state not reset after end of name");

  // Only a finished name carries a non-zero status.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.done_res |-> out_data_r.status == ST_OK)
    else $error("error status on an item that does not end the name");

  // Inside a label there is always at least one content byte left.
  a_label_left: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.want_length |-> state_r.label_left != 6'd0)
    else $error("label content expected with no bytes left");
`endif

endmodule

[dv/dnv_name_checker.sv]
// Checker for the DNS name validator: predicts every result item and compares it field by field.
`timescale 1ns / 100ps

module dnv_name_checker #(
  parameter int MAX_NAME_LEN = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  dnv_pkg::dnv_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  dnv_pkg::dnv_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output int                mismatches,
  output int                results_owed
);
  import dnv_pkg::*;

  dnv_state_t name_st = NAME_START;
  logic [7:0] limit_len = MAX_LEN_RESET;
  dnv_out_t   owed_q[$];
  int         errs = 0;

  // Advances the parser by one byte and returns the result item it gives.
  function automatic dnv_out_t next_name_result(input dnv_in_t item);
    dnv_out_t   r;
    logic [9:0] grown;
    logic       ended;
    r = '0;
    r.out_byte = item.in_byte;
    r.status = ST_OK;
    ended = 1'b0;
    if (name_st.want_length) begin
      grown = {1'b0, name_st.total_len} + {2'b00, item.in_byte} + 10'd1;
      r.is_length = 1'b1;
      if ((item.in_byte & NAME_TYPE_MASK) != 8'd0) begin
        r.status = ST_BAD_TYPE;
      end else if (grown > MAX_NAME_LEN) begin
        r.status = ST_OVER_WIRE;
      end else if (grown > {2'b00, limit_len}) begin
        r.status = ST_OVER_CFG;
      end
      if (r.status != ST_OK) begin
        // A rejected length byte leaves the running counts untouched.
        ended = 1'b1;
      end else if (item.in_byte == 8'd0) begin
        name_st.total_len = grown[8:0];
        ended = 1'b1;
      end else begin
        name_st.total_len = grown[8:0];
        name_st.label_left = item.in_byte[5:0];
        name_st.want_length = 1'b0;
        name_st.labels_seen = name_st.labels_seen + 8'd1;
        if (item.in_last) begin
          r.status = ST_TRUNC;
          ended = 1'b1;
        end
      end
    end else begin
      if (item.in_byte >= 8'h41 && item.in_byte <= 8'h5a) begin
        r.out_byte = item.in_byte + 8'h20;
      end
      name_st.label_left = name_st.label_left - 6'd1;
      if (name_st.label_left == 6'd0) begin
        name_st.want_length = 1'b1;
      end
      if (item.in_last) begin
        r.status = ST_TRUNC;
        ended = 1'b1;
      end
    end
    r.done_res = ended;
    r.name_len = name_st.total_len[7:0];
    r.label_count = name_st.labels_seen;
    if (ended) begin
      name_st = NAME_START;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    dnv_out_t want;
    if (!rst_n) begin
      name_st = NAME_START;
      limit_len = MAX_LEN_RESET;
      owed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_len = cfg_data;
      end
      // Inputs are taken before outputs so that a same-cycle pass-through still lines up.
      if (in_valid && in_ready) begin
        owed_q.push_back(next_name_result(in_data));
      end
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%0t: result item with nothing expected: byte %h", $realtime,
                     out_data.out_byte);
          end
        end else begin
          want = owed_q.pop_front();
          if (want.out_byte !== out_data.out_byte || want.is_length !== out_data.is_length ||
              want.done_res !== out_data.done_res || want.status !== out_data.status ||
              want.name_len !== out_data.name_len ||
              want.label_count !== out_data.label_count) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: expected byte %h len %b done %b st %0d nlen %0d labels %0d",
                       $realtime, want.out_byte, want.is_length, want.done_res,
                       want.status, want.name_len, want.label_count);
              $display("%0t:   actual byte %h len %b done %b st %0d nlen %0d labels %0d",
                       $realtime, out_data.out_byte, out_data.is_length, out_data.done_res,
                       out_data.status, out_data.name_len, out_data.label_count);
            end
          end
        end
      end
    end
    mismatches <= errs;
    results_owed <= owed_q.size();
  end

endmodule

[dv/dns_name_wire_validator_unit_tb.sv]
// Top of the DNS name validator testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module dns_name_wire_validator_unit_tb;
  import dnv_pkg::*;

  localparam int MAX_NAME_LEN = 255;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;

  // Each entry is a byte followed by its last flag.
  localparam logic [8:0] DIRECTED[17] = '{
    {8'h05, 1'b0}, {8'h40, 1'b0}, {8'h41, 1'b0}, {8'h5a, 1'b0}, {8'h5b, 1'b0},
    {8'hff, 1'b0}, {8'h00, 1'b0},
    {8'hc0, 1'b0}, {8'h40, 1'b0}, {8'h80, 1'b0},
    {8'h00, 1'b1},
    {8'h01, 1'b1},
    {8'h02, 1'b0}, {8'h61, 1'b1},
    {8'h01, 1'b0}, {8'h58, 1'b1},
    {8'hff, 1'b1}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  dnv_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  dnv_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  int mismatches;
  int results_owed;
  int in_idle_pct  = 29;
  int out_idle_pct = 29;
  bit hold_req     = 1'b0;
  int sent         = 0;
  int cycle_cnt    = 0;

  dns_name_wire_validator_unit #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  dnv_name_checker #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) name_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{in_byte: b, in_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stops offering items and waits until every owed result item is out.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_len(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly well-formed names with random content; some truncated, some with
  // bad length bytes, some plain noise, and a few long enough to pass 255.
  task automatic send_random_name();
    logic [7:0] name_q[$];
    logic [7:0] c;
    int         kind;
    int         labels;
    int         len;
    int         cut;
    kind = $urandom_range(99);
    if (kind < 12) begin
      len = $urandom_range(1, 8);
      repeat (len) put_byte(8'($urandom), $urandom_range(9) == 0);
      return;
    end
    labels = (kind < 16) ? $urandom_range(3, 5) : $urandom_range(0, 4);
    repeat (labels) begin
      if (kind < 16) begin
        len = $urandom_range(48, 63);
      end else if ($urandom_range(9) == 0) begin
        len = $urandom_range(13, 63);
      end else begin
        len = $urandom_range(1, 12);
      end
      if ($urandom_range(29) == 0) begin
        name_q.push_back(8'($urandom_range(8'h40, 8'hff)));
      end else begin
        name_q.push_back(8'(len));
      end
      repeat (len) begin
        case ($urandom_range(2))
          0: c = 8'($urandom_range(8'h41, 8'h5a));
          1: c = 8'($urandom_range(8'h61, 8'h7a));
          default: c = 8'($urandom);
        endcase
        name_q.push_back(c);
      end
    end
    name_q.push_back(8'h00);
    cut = name_q.size() - 1;
    if (kind < 30 && name_q.size() > 1) begin
      cut = $urandom_range(0, name_q.size() - 2);
    end
    for (int i = 0; i <= cut; i++) begin
      put_byte(name_q[i], (i == cut) &&
               (cut != name_q.size() - 1 || $urandom_range(3) == 0));
    end
  endtask

  initial begin
    logic [7:0] phase_len[6];
    int         phase_items[6];
    int         goal;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 8'd0;
    phase_len = '{8'd255, 8'd64, 8'd1, 8'd0, 8'($urandom_range(2, 254)), 8'd255};
    phase_items = '{300, 300, 100, 100, 300, 300};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < 17; i++) begin
      put_byte(DIRECTED[i][8:1], DIRECTED[i][0]);
    end

    for (int p = 0; p < 6; p++) begin
      set_max_len(phase_len[p]);
      if (p == 0) begin
        hold_req = 1'b1;
      end
      // One phase runs with no idling on either side.
      in_idle_pct = (p == 4) ? 0 : 29;
      out_idle_pct = (p == 4) ? 0 : 29;
      goal = sent + phase_items[p];
      while (sent < goal) send_random_name();
    end

    drain();
    if (mismatches == 0 && results_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
